>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the merge core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define KWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/kwm_pkg.sv
package kwm_pkg;

   // Sizing of the merge
   localparam int MAX_LISTS  = 8;
   localparam int KEY_WIDTH  = 32;
   localparam int IDX_WIDTH  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
   localparam int CNT_WIDTH  = IDX_WIDTH + 1;

   // Fixed field widths of the stream ports
   localparam int VALUE_WIDTH     = 32;
   localparam int SOURCE_WIDTH    = 3;
   localparam int NUM_LISTS_WIDTH = 4;
   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 40;

   localparam logic [NUM_LISTS_WIDTH-1:0] NUM_LISTS_RESET = NUM_LISTS_WIDTH'(MAX_LISTS);

   // Request commands
   localparam logic CMD_NEXT      = 1'b0;
   localparam logic CMD_EXHAUSTED = 1'b1;

   // Queue between front and back; depth is a power of two so the pointers wrap
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Classified request as it travels from front to back
   typedef struct packed {
      logic                 cmd;
      logic                 in_range;
      logic [IDX_WIDTH-1:0] idx;
      logic [KEY_WIDTH-1:0] key;
   } kwm_item_type;

   // Clamp the configured list count into 1 .. MAX_LISTS
   function automatic logic [CNT_WIDTH-1:0] active_count(
      input logic [NUM_LISTS_WIDTH-1:0] num_lists);
      logic [CNT_WIDTH+NUM_LISTS_WIDTH-1:0] wide;
      wide = {{CNT_WIDTH{1'b0}}, num_lists};
      if (num_lists == '0) begin
         return CNT_WIDTH'(1);
      end else if (wide > (CNT_WIDTH+NUM_LISTS_WIDTH)'(MAX_LISTS)) begin
         return CNT_WIDTH'(MAX_LISTS);
      end
      return wide[CNT_WIDTH-1:0];
   endfunction

   // Low KEY_WIDTH bits of the value, zero filled above 32 bits
   function automatic logic [KEY_WIDTH-1:0] key_from_value(
      input logic [VALUE_WIDTH-1:0] value);
      logic [KEY_WIDTH+VALUE_WIDTH-1:0] wide;
      wide = {{KEY_WIDTH{1'b0}}, value};
      return wide[KEY_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] value_from_key(
      input logic [KEY_WIDTH-1:0] key);
      logic [KEY_WIDTH+VALUE_WIDTH-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, key};
      return wide[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [IDX_WIDTH-1:0] idx_from_source(
      input logic [SOURCE_WIDTH-1:0] source);
      logic [IDX_WIDTH+SOURCE_WIDTH-1:0] wide;
      wide = {{IDX_WIDTH{1'b0}}, source};
      return wide[IDX_WIDTH-1:0];
   endfunction

   function automatic logic [SOURCE_WIDTH-1:0] source_from_idx(
      input logic [IDX_WIDTH-1:0] idx);
      logic [IDX_WIDTH+SOURCE_WIDTH-1:0] wide;
      wide = {{SOURCE_WIDTH{1'b0}}, idx};
      return wide[SOURCE_WIDTH-1:0];
   endfunction

   // Source below the active list count
   function automatic logic source_in_range(
      input logic [SOURCE_WIDTH-1:0] source,
      input logic [CNT_WIDTH-1:0]    count);
      logic [CNT_WIDTH+SOURCE_WIDTH-1:0] s_wide;
      logic [CNT_WIDTH+SOURCE_WIDTH-1:0] c_wide;
      s_wide = {{CNT_WIDTH{1'b0}}, source};
      c_wide = {{SOURCE_WIDTH{1'b0}}, count};
      return s_wide < c_wide;
   endfunction

endpackage

>>> hw/rtl/kwm_front.sv
module kwm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [kwm_pkg::CNT_WIDTH-1:0]         active_cnt,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: source [2:0], value [34:3], zero pad [39:35]
   input  logic [kwm_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // tuser: command
   input  logic                                  req_tuser,
   output logic                                  item_valid,
   input  logic                                  item_ready,
   output kwm_pkg::kwm_item_type                 item
);
   import kwm_pkg::*;

   logic         valid_ff, valid_in;
   kwm_item_type item_ff, item_in;
   logic [SOURCE_WIDTH-1:0] source;
   logic         accept;

   assign req_tready = !valid_ff || item_ready;
   assign accept     = req_tvalid && req_tready;
   assign source     = req_tdata[SOURCE_WIDTH-1:0];

   // Classify the request: decode fields and flag sources past the list count
   always_comb begin
      item_in          = item_ff;
      valid_in         = valid_ff && !item_ready;
      if (accept) begin
         item_in.cmd      = req_tuser;
         item_in.in_range = source_in_range(source, active_cnt);
         item_in.idx      = idx_from_source(source);
         item_in.key      = key_from_value(req_tdata[SOURCE_WIDTH +: VALUE_WIDTH]);
         valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/kwm_queue.sv
`include "assert_macros.svh"

module kwm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  kwm_pkg::kwm_item_type  in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output kwm_pkg::kwm_item_type  out_item
);
   import kwm_pkg::*;

   kwm_item_type           mem [QUEUE_DEPTH];
   kwm_item_type           out_item_ff;
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = out_item_ff;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

   // Register the next head; forward a request pushed into the head slot
   always_ff @(posedge clock) begin
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         out_item_ff <= in_item;
      end else begin
         out_item_ff <= mem[rd_ptr_in];
      end
   end

   `KWM_ASSERT(a_queue_bound, count_ff <= QCNT_WIDTH'(QUEUE_DEPTH), "queue over capacity")

endmodule

>>> hw/rtl/kwm_back.sv
`include "assert_macros.svh"

module kwm_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [kwm_pkg::CNT_WIDTH-1:0]         active_cnt,
   input  logic                                  item_valid,
   output logic                                  item_ready,
   input  kwm_pkg::kwm_item_type                 item,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: value_res [31:0], source_res [34:32], zero pad [39:35]
   output logic [kwm_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // tuser: done_res
   output logic                                  rsp_tuser
);
   import kwm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [MAX_LISTS-1:0]    has_head_ff, has_head_in;
   logic [MAX_LISTS-1:0]    exhausted_ff, exhausted_in;
   logic [KEY_WIDTH-1:0]    head_value_ff [MAX_LISTS];
   logic                    head_we;
   logic [IDX_WIDTH-1:0]    scan_idx_ff, scan_idx_in;
   logic                    found_ff, found_in;
   logic [IDX_WIDTH-1:0]    best_idx_ff, best_idx_in;
   logic [KEY_WIDTH-1:0]    best_key_ff, best_key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic [SOURCE_WIDTH-1:0] rsp_source_ff, rsp_source_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic [MAX_LISTS-1:0]    act_mask;
   logic                    all_settled;
   logic [KEY_WIDTH-1:0]    head_rd_ff;
   logic                    better;
   logic                    scan_last;
   logic                    out_free;
   logic                    item_busy;

   // Lists below the active count take part
   always_comb begin
      for (int i = 0; i < MAX_LISTS; i++) begin
         act_mask[i] = CNT_WIDTH'(i) < active_cnt;
      end
   end

   assign all_settled = ((has_head_ff | exhausted_ff) & act_mask) == act_mask;
   assign better      = has_head_ff[scan_idx_ff]
                        && (!found_ff || ($signed(head_rd_ff) < $signed(best_key_ff)));
   assign scan_last   = {1'b0, scan_idx_ff} == (active_cnt - CNT_WIDTH'(1));
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign item_busy   = has_head_ff[item.idx] || exhausted_ff[item.idx];
   assign item_ready  = state_ff == ST_IDLE;

   // Sequencer: apply request, check, scan heads, emit
   always_comb begin
      state_in      = state_ff;
      has_head_in   = has_head_ff;
      exhausted_in  = exhausted_ff;
      head_we       = 1'b0;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_source_in = rsp_source_ff;
      rsp_done_in   = rsp_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               // Take the item only for a list that awaits data
               if (item.in_range && !item_busy) begin
                  if (item.cmd == CMD_NEXT) begin
                     head_we                = 1'b1;
                     has_head_in[item.idx]  = 1'b1;
                  end else begin
                     exhausted_in[item.idx] = 1'b1;
                  end
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (all_settled) begin
               scan_idx_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               state_in    = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // One comparison per cycle; strict less keeps the lowest index on ties
            if (better) begin
               found_in    = 1'b1;
               best_idx_in = scan_idx_ff;
               best_key_in = head_rd_ff;
            end
            if (scan_last) begin
               state_in    = ST_EMIT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  has_head_in[best_idx_ff] = 1'b0;
                  rsp_value_in  = value_from_key(best_key_ff);
                  rsp_source_in = source_from_idx(best_idx_ff);
                  rsp_done_in   = 1'b0;
               end else begin
                  exhausted_in  = '0;
                  rsp_value_in  = '0;
                  rsp_source_in = '0;
                  rsp_done_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         has_head_ff  <= '0;
         exhausted_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         has_head_ff  <= has_head_in;
         exhausted_ff <= exhausted_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_source_ff <= rsp_source_in;
      rsp_done_ff   <= rsp_done_in;
   end

   // Head store: one write port, one registered read port at the next scan index
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_value_ff[item.idx] <= item.key;
      end
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_value_ff[scan_idx_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-VALUE_WIDTH-SOURCE_WIDTH){1'b0}},
                        rsp_source_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_done_ff;

   `KWM_ASSERT(a_scan_settled, (state_ff == ST_SCAN) |-> all_settled, "scan with a list awaiting data")
   `KWM_ASSERT(a_emit_has_head, (state_ff == ST_EMIT && found_ff) |-> has_head_ff[best_idx_ff], "emitting an empty head")
   `KWM_ASSERT(a_done_clears, (state_ff == ST_EMIT && out_free && !found_ff) |=> (exhausted_ff == '0), "exhausted marks left after done")

endmodule

>>> hw/rtl/k_way_sorted_merge_core.sv
// K-way merge of ascending key streams. Each request carries either the next key of one
// source list or an exhausted mark for it; once every active list holds a head or is
// exhausted, the core returns the smallest head (lowest list on ties) together with its
// list, which must then send its next request. When all active lists are exhausted a
// done response follows and the exhausted marks are cleared. Requests for lists that are
// not waiting, or at or above the list count, are dropped. In the back end, a request that
// does not complete the set of heads goes from idle through the check state back to idle;
// one that does is followed by a scan of the stored heads by the single signed comparator,
// one per cycle, and then the emit state. A two-entry queue behind the input register
// keeps accepting requests meanwhile, and the response register frees the back end as
// soon as the downstream side takes the result. Write csr_wr_data only while idle.
module k_way_sorted_merge_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [kwm_pkg::NUM_LISTS_WIDTH-1:0]   csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: source [2:0], value [34:3], zero pad [39:35]
   input  logic [kwm_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // tuser: command
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: value_res [31:0], source_res [34:32], zero pad [39:35]
   output logic [kwm_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // tuser: done_res
   output logic                                  rsp_tuser
);
   import kwm_pkg::*;

   logic [NUM_LISTS_WIDTH-1:0] num_lists_ff;
   logic [CNT_WIDTH-1:0]       active_cnt;
   logic                       f_valid, f_ready;
   kwm_item_type               f_item;
   logic                       q_valid, q_ready;
   kwm_item_type               q_item;

   // Hold the list count register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_lists_ff <= NUM_LISTS_RESET;
      end else if (csr_wr_en) begin
         num_lists_ff <= csr_wr_data;
      end
   end

   assign active_cnt = active_count(num_lists_ff);

   kwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .active_cnt (active_cnt),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   kwm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   kwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .active_cnt (active_cnt),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
